[rtl/mrq_pkg.sv]
// ----------------------------------------------------------------------------
// mrq_pkg: shared types and constants of the motion rate qualifier
// Register indexes, reset values, saturation limits and alert level codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mrq_pkg;

   localparam logic [1:0] REG_ARMED    = 2'd0;
   localparam logic [1:0] REG_DEBOUNCE = 2'd1;
   localparam logic [1:0] REG_WINDOW   = 2'd2;

   localparam logic        ARMED_RESET    = 1'b1;
   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [23:0] WINDOW_RESET   = 24'd60000;

   localparam logic [15:0] TALLY_MAX = 16'hFFFF;
   localparam logic [5:0]  COUNT_MAX = 6'd63;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic [1:0] LEVEL_LOW    = 2'd0;
   localparam logic [1:0] LEVEL_MEDIUM = 2'd1;
   localparam logic [1:0] LEVEL_HIGH   = 2'd2;

   typedef struct packed {
      logic [31:0] now_ms;
      logic [23:0] window_ms;
   } mrq_sweep_type;

endpackage

`default_nettype wire

[rtl/mrq_if.sv]
// ----------------------------------------------------------------------------
// mrq_if: request and response channels of the motion rate qualifier
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface mrq_req_if;
   logic        valid;
   logic        ready;
   logic        operation;
   logic        pir_level;
   logic [31:0] now_ms;

   modport source (output valid, output operation, output pir_level, output now_ms,
                   input ready);
   modport sink (input valid, input operation, input pir_level, input now_ms,
                 output ready);
endinterface

interface mrq_rsp_if;
   logic        valid;
   logic        ready;
   logic        motion_active;
   logic        alert_raised;
   logic        motion_cleared;
   logic [15:0] alert_total;
   logic [5:0]  window_count;
   logic [1:0]  alert_level;

   modport source (output valid, output motion_active, output alert_raised,
                   output motion_cleared, output alert_total, output window_count,
                   output alert_level, input ready);
   modport sink (input valid, input motion_active, input alert_raised,
                 input motion_cleared, input alert_total, input window_count,
                 input alert_level, output ready);
endinterface

`default_nettype wire

[rtl/mrq_cell.sv]
// ----------------------------------------------------------------------------
// mrq_cell: one event slot of the window counting chain
// Holds one event time, shifts it on to the next slot when a new event is
// stored, and adds its own window hit to the partial count from its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module mrq_cell #(
   parameter int INDEX = 0,
   parameter int CW    = 6
) (
   input  wire                 clock,
   input  wire                 shift_en,
   input  wire  [31:0]         shift_time,
   input  wire  mrq_pkg::mrq_sweep_type sweep,
   input  wire  [CW-1:0]       stored_count,
   input  wire  [CW-1:0]       count_in,
   output logic [31:0]         time_out,
   output logic [CW-1:0]       count_out
);

   logic [31:0]   time_ff;
   logic [31:0]   time_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in_next;
   logic [31:0]   age;
   logic          hit;

   always_comb begin
      time_in = shift_en ? shift_time : time_ff;
      age = sweep.now_ms - time_ff;
      hit = (stored_count > CW'(INDEX)) && (age <= {8'd0, sweep.window_ms});
      count_in_next = count_in + CW'(hit);
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      count_ff <= count_in_next;
   end

   assign time_out = time_ff;
   assign count_out = count_ff;

endmodule

`default_nettype wire

[rtl/motion_rate_qualifier.sv]
// ----------------------------------------------------------------------------
// motion_rate_qualifier: debounced motion detector with window event count
// Debounces the sensor level, counts armed rises, keeps recent rise times in
// a chain of slots and counts those inside the time window.
// ----------------------------------------------------------------------------
//
//   channel  direction  transfer when         payload
//   req      in         req.valid & ready     operation, pir_level, now_ms
//   rsp      out        rsp.valid & ready     flags, alert_total, window_count, level
//   csr      in         csr_we                csr_index, csr_wdata
//
// Each item's result is offered once the partial count has rippled along the
// chain, one slot per cycle, and a new transfer is taken only in the idle state,
// after the result of the last item has been loaded.
// The result register lets the next item enter while a result waits.
// Synchronous active high reset clears the control state and loads the configuration registers with their reset values.
// A stalled response holds the finished count until it can be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module motion_rate_qualifier #(
   parameter int EVENT_SLOTS = 32
) (
   input  wire         clock,
   input  wire         reset,
   mrq_req_if.sink     req,
   mrq_rsp_if.source   rsp,
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [23:0] csr_wdata
);

   localparam int CW = $clog2(EVENT_SLOTS + 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   logic        armed_ff;
   logic [15:0] debounce_ff;
   logic [23:0] window_ff;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] sweep_cnt_ff, sweep_cnt_in;
   logic          motion_ff, motion_in;
   logic [31:0]   last_change_ff, last_change_in;
   logic [CW-1:0] stored_ff, stored_in;
   logic [15:0]   tally_ff, tally_in;
   logic [31:0]   now_ff;
   logic          raised_ff, raised_in;
   logic          cleared_ff, cleared_in;

   logic          out_valid_ff, out_valid_in;
   logic          out_motion_ff;
   logic          out_raised_ff;
   logic          out_cleared_ff;
   logic [15:0]   out_total_ff;
   logic [5:0]    out_count_ff;
   logic [1:0]    out_level_ff;

   logic          accept;
   logic          change;
   logic          event_store;
   logic          sweep_done;
   logic          load_out;
   logic [5:0]    count_sat;
   logic [1:0]    level;
   logic [CW+5:0] count_ext;

   logic [31:0]   time_chain [EVENT_SLOTS];
   logic [CW-1:0] count_chain [EVENT_SLOTS];
   mrq_pkg::mrq_sweep_type sweep;

   assign req.ready = (state_ff == ST_IDLE);
   assign accept = req.valid && req.ready;
   assign change = (req.pir_level != motion_ff) &&
                   ((req.now_ms - last_change_ff) > {16'd0, debounce_ff});
   assign event_store = accept && (req.operation == mrq_pkg::OP_SAMPLE) && change &&
                        req.pir_level && armed_ff;
   assign sweep = {now_ff, window_ff};

   for (genvar i = 0; i < EVENT_SLOTS; i++) begin : g_cell
      logic [31:0]   shift_time;
      logic [CW-1:0] count_prev;
      if (i == 0) begin : g_head
         assign shift_time = req.now_ms;
         assign count_prev = '0;
      end else begin : g_body
         assign shift_time = time_chain[i-1];
         assign count_prev = count_chain[i-1];
      end
      mrq_cell #(
         .INDEX (i),
         .CW    (CW)
      ) u_cell (
         .clock        (clock),
         .shift_en     (event_store),
         .shift_time   (shift_time),
         .sweep        (sweep),
         .stored_count (stored_ff),
         .count_in     (count_prev),
         .time_out     (time_chain[i]),
         .count_out    (count_chain[i])
      );
   end

   always_comb begin
      count_ext = (CW + 6)'(count_chain[EVENT_SLOTS-1]);
      count_sat = (count_ext > (CW + 6)'(mrq_pkg::COUNT_MAX)) ?
                  mrq_pkg::COUNT_MAX : count_ext[5:0];
      if (count_sat >= 6'd3) begin
         level = mrq_pkg::LEVEL_HIGH;
      end else if (count_sat == 6'd2) begin
         level = mrq_pkg::LEVEL_MEDIUM;
      end else begin
         level = mrq_pkg::LEVEL_LOW;
      end
   end

   always_comb begin
      state_in = state_ff;
      sweep_cnt_in = sweep_cnt_ff;
      motion_in = motion_ff;
      last_change_in = last_change_ff;
      stored_in = stored_ff;
      tally_in = tally_ff;
      raised_in = raised_ff;
      cleared_in = cleared_ff;
      sweep_done = 1'b0;
      load_out = 1'b0;
      out_valid_in = out_valid_ff && !rsp.ready;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               sweep_cnt_in = '0;
               raised_in = 1'b0;
               cleared_in = 1'b0;
               if (req.operation == mrq_pkg::OP_CLEAR) begin
                  tally_in = '0;
                  stored_in = '0;
               end else if (change) begin
                  motion_in = req.pir_level;
                  last_change_in = req.now_ms;
                  if (!req.pir_level) begin
                     cleared_in = 1'b1;
                  end else if (armed_ff) begin
                     raised_in = 1'b1;
                     if (tally_ff != mrq_pkg::TALLY_MAX) begin
                        tally_in = tally_ff + 16'd1;
                     end
                     if (stored_ff != CW'(EVENT_SLOTS)) begin
                        stored_in = stored_ff + CW'(1);
                     end
                  end
               end
            end
         end
         ST_RUN: begin
            if (sweep_cnt_ff == CW'(EVENT_SLOTS)) begin
               sweep_done = 1'b1;
            end else begin
               sweep_cnt_in = sweep_cnt_ff + CW'(1);
            end
         end
         ST_HOLD: begin
            sweep_done = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (sweep_done) begin
         if (!out_valid_ff || rsp.ready) begin
            load_out = 1'b1;
            out_valid_in = 1'b1;
            state_in = ST_IDLE;
         end else begin
            state_in = ST_HOLD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= mrq_pkg::ARMED_RESET;
         debounce_ff <= mrq_pkg::DEBOUNCE_RESET;
         window_ff <= mrq_pkg::WINDOW_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            mrq_pkg::REG_ARMED:    armed_ff <= csr_wdata[0];
            mrq_pkg::REG_DEBOUNCE: debounce_ff <= csr_wdata[15:0];
            mrq_pkg::REG_WINDOW:   window_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sweep_cnt_ff <= '0;
         motion_ff <= 1'b0;
         last_change_ff <= '0;
         stored_ff <= '0;
         tally_ff <= '0;
         raised_ff <= 1'b0;
         cleared_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sweep_cnt_ff <= sweep_cnt_in;
         motion_ff <= motion_in;
         last_change_ff <= last_change_in;
         stored_ff <= stored_in;
         tally_ff <= tally_in;
         raised_ff <= raised_in;
         cleared_ff <= cleared_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff <= req.now_ms;
      end
      if (load_out) begin
         out_motion_ff <= motion_ff;
         out_raised_ff <= raised_ff;
         out_cleared_ff <= cleared_ff;
         out_total_ff <= tally_ff;
         out_count_ff <= count_sat;
         out_level_ff <= level;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.motion_active = out_motion_ff;
   assign rsp.alert_raised = out_raised_ff;
   assign rsp.motion_cleared = out_cleared_ff;
   assign rsp.alert_total = out_total_ff;
   assign rsp.window_count = out_count_ff;
   assign rsp.alert_level = out_level_ff;

`ifndef SYNTHESIS
   a_stored_bound: assert property (@(posedge clock) disable iff (reset)
      stored_ff <= CW'(EVENT_SLOTS))
      else $error("stored event count exceeds the slot count");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      accept && (req.operation == mrq_pkg::OP_CLEAR) |=> (stored_ff == '0) &&
      (tally_ff == '0))
      else $error("clear transfer did not empty the ring and total");

   a_raise_flags: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.alert_raised |-> rsp.motion_active && !rsp.motion_cleared)
      else $error("alert raised without an active motion state");

   a_load_after_sweep: assert property (@(posedge clock) disable iff (reset)
      load_out |-> $past(state_ff != ST_IDLE))
      else $error("result loaded without a finished sweep");
`endif

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb: testbench of the motion rate qualifier
// Drives sensor samples and clear items through the request channel under
// several register settings and idle patterns, predicts every status result
// in a model of its own, and compares each response transfer field by field.
// ----------------------------------------------------------------------------

module tb;

   localparam int         SLOTS       = 32;
   localparam int         PIPE_CYCLES = SLOTS + 2;
   localparam logic [1:0] REG_SPARE   = 2'd3;

   typedef struct packed {
      logic        motion_active;
      logic        alert_raised;
      logic        motion_cleared;
      logic [15:0] alert_total;
      logic [5:0]  window_count;
      logic [1:0]  alert_level;
   } status_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [23:0] csr_wdata;

   mrq_req_if req_if ();
   mrq_rsp_if rsp_if ();

   motion_rate_qualifier #(
      .EVENT_SLOTS(SLOTS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic        cfg_armed;
   logic [15:0] cfg_debounce;
   logic [23:0] cfg_window;
   logic        motion_flag;
   logic [31:0] last_change_ms;
   logic [31:0] event_ring [SLOTS];
   int unsigned ring_slot;
   int unsigned ring_count;
   logic [15:0] alert_tally;

   status_type  expected_status_q [$];
   int          fail_count;
   int          item_count;
   int          alert_count;
   int          clear_count;
   int          peak_window;
   int          idle_pct;
   int          stall_pct;
   logic        rx_hold;
   logic [31:0] cur_ms;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic status_type qualify_motion(input logic op, input logic pir,
                                                 input logic [31:0] now);
      status_type  s;
      logic [31:0] age;
      int          n;
      int          i;
      s = '0;
      if (op == mrq_pkg::OP_CLEAR) begin
         alert_tally = '0;
         ring_count  = 0;
         ring_slot   = 0;
      end else if (pir != motion_flag && (now - last_change_ms) > {16'd0, cfg_debounce}) begin
         motion_flag    = pir;
         last_change_ms = now;
         if (pir) begin
            if (cfg_armed) begin
               s.alert_raised = 1'b1;
               if (alert_tally != mrq_pkg::TALLY_MAX) alert_tally = alert_tally + 16'd1;
               event_ring[ring_slot] = now;
               ring_slot = (ring_slot + 1) % SLOTS;
               if (ring_count < SLOTS) ring_count++;
            end
         end else begin
            s.motion_cleared = 1'b1;
         end
      end
      n = 0;
      for (i = 0; i < ring_count; i++) begin
         age = now - event_ring[i];
         if (age <= {8'd0, cfg_window}) n++;
      end
      if (n > int'(mrq_pkg::COUNT_MAX)) n = int'(mrq_pkg::COUNT_MAX);
      s.motion_active = motion_flag;
      s.alert_total   = alert_tally;
      s.window_count  = n[5:0];
      s.alert_level   = (n >= 3) ? mrq_pkg::LEVEL_HIGH :
                        (n == 2) ? mrq_pkg::LEVEL_MEDIUM : mrq_pkg::LEVEL_LOW;
      return s;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      status_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_status_q.size() == 0) begin
            $error("response transfer with no status expected");
            fail_count++;
         end else begin
            want = expected_status_q.pop_front();
            check_field("motion_active", 16'(want.motion_active),
                        16'(rsp_if.motion_active));
            check_field("alert_raised", 16'(want.alert_raised),
                        16'(rsp_if.alert_raised));
            check_field("motion_cleared", 16'(want.motion_cleared),
                        16'(rsp_if.motion_cleared));
            check_field("alert_total", want.alert_total, rsp_if.alert_total);
            check_field("window_count", 16'(want.window_count),
                        16'(rsp_if.window_count));
            check_field("alert_level", 16'(want.alert_level),
                        16'(rsp_if.alert_level));
         end
      end
      if (rx_hold) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_item(input logic op, input logic pir, input logic [31:0] now);
      status_type s;
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.pir_level <= pir;
      req_if.now_ms    <= now;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      s = qualify_motion(op, pir, now);
      expected_status_q.push_back(s);
      item_count++;
      if (s.alert_raised) alert_count++;
      if (op == mrq_pkg::OP_CLEAR) clear_count++;
      if (int'(s.window_count) > peak_window) peak_window = int'(s.window_count);
      if ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (expected_status_q.size() != 0) @(posedge clock);
      repeat (PIPE_CYCLES + 4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         mrq_pkg::REG_ARMED:    cfg_armed    = value[0];
         mrq_pkg::REG_DEBOUNCE: cfg_debounce = value[15:0];
         mrq_pkg::REG_WINDOW:   cfg_window   = value;
         default: ;
      endcase
   endtask

   task automatic hold_receiver(input int cycles);
      rx_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      rx_hold <= 1'b0;
   endtask

   task automatic random_item();
      logic [31:0] step;
      logic        pir;
      int          r;
      r = $urandom_range(99);
      if (r < 5) begin
         send_item(mrq_pkg::OP_CLEAR, 1'($urandom_range(1)), cur_ms);
         return;
      end
      if (r < 10) begin
         cur_ms = $urandom;
         send_item(mrq_pkg::OP_SAMPLE, 1'($urandom_range(1)), cur_ms);
         return;
      end
      r = $urandom_range(99);
      if (r < 45) begin
         step = $urandom_range(0, cfg_debounce + cfg_debounce / 2 + 2);
      end else if (r < 85) begin
         step = $urandom_range(0, 2000);
      end else if (r < 97) begin
         step = $urandom_range(0, cfg_window + 1000);
      end else begin
         step = $urandom;
      end
      cur_ms = cur_ms + step;
      pir = ($urandom_range(99) < 70) ? !motion_flag : motion_flag;
      send_item(mrq_pkg::OP_SAMPLE, pir, cur_ms);
   endtask

   task automatic run_random(input int count, input int send_idle, input int rx_stall);
      idle_pct  = send_idle;
      stall_pct <= rx_stall;
      repeat (count) random_item();
      drain_results();
   endtask

   task automatic test_debounce_defaults();
      send_item(mrq_pkg::OP_SAMPLE, 1'b1, 32'd0);
      send_item(mrq_pkg::OP_SAMPLE, 1'b1, 32'd51);
      send_item(mrq_pkg::OP_SAMPLE, 1'b0, 32'd60);
      send_item(mrq_pkg::OP_SAMPLE, 1'b0, 32'd101);
      send_item(mrq_pkg::OP_SAMPLE, 1'b0, 32'd102);
      send_item(mrq_pkg::OP_SAMPLE, 1'b0, 32'd500);
      send_item(mrq_pkg::OP_SAMPLE, 1'b1, 32'd600);
      send_item(mrq_pkg::OP_SAMPLE, 1'b0, 32'd700);
      send_item(mrq_pkg::OP_SAMPLE, 1'b1, 32'd800);
      send_item(mrq_pkg::OP_SAMPLE, 1'b1, 32'd60800);
      send_item(mrq_pkg::OP_SAMPLE, 1'b1, 32'd60801);
   endtask

   task automatic test_clear();
      send_item(mrq_pkg::OP_CLEAR, 1'b1, 32'd60900);
      send_item(mrq_pkg::OP_SAMPLE, 1'b0, 32'd61000);
      send_item(mrq_pkg::OP_SAMPLE, 1'b1, 32'd61100);
   endtask

   task automatic test_disarmed();
      drain_results();
      write_reg(mrq_pkg::REG_ARMED, 24'd0);
      send_item(mrq_pkg::OP_SAMPLE, 1'b0, 32'd61200);
      send_item(mrq_pkg::OP_SAMPLE, 1'b1, 32'd61300);
      drain_results();
      write_reg(mrq_pkg::REG_ARMED, 24'hFFFFFF);
   endtask

   task automatic test_register_extremes();
      write_reg(mrq_pkg::REG_DEBOUNCE, 24'd0);
      write_reg(mrq_pkg::REG_WINDOW, 24'd0);
      write_reg(REG_SPARE, 24'hFFFFFF);
      send_item(mrq_pkg::OP_SAMPLE, 1'b0, 32'hFFFF_FFF0);
      send_item(mrq_pkg::OP_SAMPLE, 1'b1, 32'hFFFF_FFF0);
      send_item(mrq_pkg::OP_SAMPLE, 1'b1, 32'hFFFF_FFFF);
      send_item(mrq_pkg::OP_SAMPLE, 1'b0, 32'h0000_0003);
      drain_results();
      write_reg(mrq_pkg::REG_WINDOW, 24'hFFFFFF);
      send_item(mrq_pkg::OP_SAMPLE, 1'b0, 32'd4);
      send_item(mrq_pkg::OP_SAMPLE, 1'b1, 32'd5);
      // The event stored at time five lies ahead of now and must not count.
      send_item(mrq_pkg::OP_SAMPLE, 1'b0, 32'd2);
      drain_results();
      write_reg(mrq_pkg::REG_DEBOUNCE, 24'h00FFFF);
      send_item(mrq_pkg::OP_SAMPLE, 1'b1, 32'd65537);
      send_item(mrq_pkg::OP_SAMPLE, 1'b1, 32'd65538);
      cur_ms = 32'd65538;
      drain_results();
   endtask

   task automatic test_no_idle();
      write_reg(mrq_pkg::REG_ARMED, 24'd1);
      write_reg(mrq_pkg::REG_DEBOUNCE, 24'd50);
      write_reg(mrq_pkg::REG_WINDOW, 24'd60000);
      run_random(400, 0, 0);
   endtask

   task automatic test_ring_wrap();
      write_reg(mrq_pkg::REG_DEBOUNCE, 24'($urandom_range(0, 20)));
      write_reg(mrq_pkg::REG_WINDOW, 24'hFFFFFF);
      run_random(400, 59, 0);
   endtask

   task automatic test_rx_stall();
      write_reg(mrq_pkg::REG_ARMED, 24'($urandom));
      write_reg(mrq_pkg::REG_DEBOUNCE, 24'($urandom_range(0, 300)));
      write_reg(mrq_pkg::REG_WINDOW, 24'($urandom));
      run_random(400, 0, 59);
   endtask

   task automatic test_slow_debounce();
      write_reg(mrq_pkg::REG_ARMED, 24'd1);
      write_reg(mrq_pkg::REG_DEBOUNCE, 24'h00FFFF);
      write_reg(mrq_pkg::REG_WINDOW, 24'd0);
      run_random(300, 12, 12);
   endtask

   task automatic test_backpressure();
      write_reg(mrq_pkg::REG_DEBOUNCE, 24'd20);
      write_reg(mrq_pkg::REG_WINDOW, 24'd100000);
      idle_pct  = 0;
      stall_pct <= 0;
      fork
         hold_receiver(400);
      join_none
      repeat (100) random_item();
      drain_results();
   endtask

   task automatic test_random_mix();
      repeat (3) begin
         write_reg(mrq_pkg::REG_ARMED, 24'($urandom));
         write_reg(mrq_pkg::REG_DEBOUNCE, 24'($urandom_range(0, 1000)));
         write_reg(mrq_pkg::REG_WINDOW, 24'($urandom_range(0, 200000)));
         run_random(120, 12, 12);
      end
   endtask

   initial begin
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_index        = mrq_pkg::REG_ARMED;
      csr_wdata        = '0;
      req_if.valid     = 1'b0;
      req_if.operation = mrq_pkg::OP_SAMPLE;
      req_if.pir_level = 1'b0;
      req_if.now_ms    = '0;
      rsp_if.ready     = 1'b0;
      rx_hold          = 1'b0;
      idle_pct         = 0;
      stall_pct        = 0;
      cur_ms           = '0;
      fail_count       = 0;
      item_count       = 0;
      alert_count      = 0;
      clear_count      = 0;
      peak_window      = 0;
      cfg_armed        = mrq_pkg::ARMED_RESET;
      cfg_debounce     = mrq_pkg::DEBOUNCE_RESET;
      cfg_window       = mrq_pkg::WINDOW_RESET;
      motion_flag      = 1'b0;
      last_change_ms   = '0;
      ring_slot        = 0;
      ring_count       = 0;
      alert_tally      = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_debounce_defaults();
      test_clear();
      test_disarmed();
      test_register_extremes();
      test_no_idle();
      test_ring_wrap();
      test_rx_stall();
      test_slow_debounce();
      test_backpressure();
      test_random_mix();
      drain_results();
      $display("summary: %0d items, %0d alerts, %0d clears, highest window count %0d",
               item_count, alert_count, clear_count, peak_window);
      $display("summary: register extremes, disarmed rises, wrapped time and ring wrap");
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
